// File: hw/rtl/tlbl_pkg.sv
// Shared types and constants of the LFU translation lookaside buffer.
// Used by the interfaces, the match and victim units and the top level.
// Depends on nothing.
package tlbl_pkg;

    localparam int CNT_W       = 16;
    localparam int CFG_W       = 4;
    localparam int OUT_FRAME_W = 20;
    localparam int SLOT_W      = 3;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [CFG_W-1:0] RESET_ENTRIES = 4'd5;

    // Register index decoded from paddr[2].
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_FLUSH  = 2'd2
    } t_kind;

    typedef struct packed {
        logic                   hit;
        logic [OUT_FRAME_W-1:0] frame_out;
        logic [SLOT_W-1:0]      slot;
    } t_rsp;

endpackage

// File: hw/rtl/tlbl_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on tlbl_pkg for the fixed response field widths.
interface tlbl_req_if #(
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 20
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;

    modport source (output valid, output kind, output page, output frame, input ready);
    modport sink   (input valid, input kind, input page, input frame, output ready);
endinterface

interface tlbl_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic [tlbl_pkg::OUT_FRAME_W-1:0] frame_out;
    logic [tlbl_pkg::SLOT_W-1:0]      slot;

    modport source (output valid, output hit, output frame_out, output slot, input ready);
    modport sink   (input valid, input hit, input frame_out, input slot, output ready);
endinterface

// File: hw/rtl/tlbl_match.sv
// Associative page compare over the active entries, lowest matching entry wins.
// Depends on tlbl_pkg for the entry count register width.
module tlbl_match #(
    parameter int ENTRIES   = 8,
    parameter int PAGE_BITS = 20
) (
    input  logic [PAGE_BITS-1:0]       i_page,
    input  logic [PAGE_BITS-1:0]       i_page_store [ENTRIES],
    input  logic [ENTRIES-1:0]         i_valid,
    input  logic [tlbl_pkg::CFG_W-1:0] i_count,
    output logic                       o_hit,
    output logic [ENTRIES-1:0]         o_hit_oh,
    output logic [$clog2(ENTRIES)-1:0] o_hit_idx
);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int LIMIT = (ENTRIES < 15) ? ENTRIES : 15;

    logic [ENTRIES-1:0] match;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = (i < LIMIT) && (i < int'(i_count)) && i_valid[i]
                       && (i_page_store[i] == i_page);
        end
    end

    // Lowest set bit wins, as a duplicated page resolves to its first entry.
    always_comb begin
        logic found;
        found     = 1'b0;
        o_hit_oh  = '0;
        o_hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match[i] && !found) begin
                found       = 1'b1;
                o_hit_oh[i] = 1'b1;
                o_hit_idx   = IDX_W'(i);
            end
        end
        o_hit = found;
    end

endmodule

// File: hw/rtl/tlbl_victim.sv
// Insert target selection: first free entry, else least-used entry with a
// rotating tie break. Depends on tlbl_pkg for count and register widths.
module tlbl_victim #(
    parameter int ENTRIES = 8
) (
    input  logic [tlbl_pkg::CNT_W-1:0] i_cnt [ENTRIES],
    input  logic [ENTRIES-1:0]         i_valid,
    input  logic [tlbl_pkg::CFG_W-1:0] i_count,
    input  logic [tlbl_pkg::CFG_W-1:0] i_ptr,
    output logic                       o_full,
    output logic [ENTRIES-1:0]         o_tgt_oh,
    output logic [$clog2(ENTRIES)-1:0] o_tgt_idx
);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int LIMIT = (ENTRIES < 15) ? ENTRIES : 15;

    logic [ENTRIES-1:0] in_range;
    logic [ENTRIES-1:0] free;
    logic [ENTRIES-1:0] is_min;
    logic [ENTRIES-1:0] tie_hi;

    // Each entry is a minimum when no active entry holds a smaller count;
    // the pairwise compares are all independent.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            in_range[i] = (i < LIMIT) && (i < int'(i_count));
        end
        for (int i = 0; i < ENTRIES; i++) begin
            free[i]   = in_range[i] && !i_valid[i];
            is_min[i] = in_range[i];
            for (int j = 0; j < LIMIT; j++) begin
                if (in_range[j] && (i_cnt[j] < i_cnt[i])) begin
                    is_min[i] = 1'b0;
                end
            end
            tie_hi[i] = is_min[i] && (i >= int'(i_ptr));
        end
    end

    always_comb begin
        logic [ENTRIES-1:0] pick;
        logic               found;
        o_full = (free == '0);
        if (!o_full) begin
            pick = free;
        end else if (tie_hi != '0) begin
            pick = tie_hi;
        end else begin
            pick = is_min;
        end
        found     = 1'b0;
        o_tgt_oh  = '0;
        o_tgt_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (pick[i] && !found) begin
                found       = 1'b1;
                o_tgt_oh[i] = 1'b1;
                o_tgt_idx   = IDX_W'(i);
            end
        end
    end

endmodule

// File: hw/rtl/tlb_lfu_lookup_insert.sv
// Top level of the fully associative TLB with least-frequently-used replacement.
// Depends on tlbl_pkg, tlbl_if, tlbl_match and tlbl_victim.
//
// Usage. Requests arrive as beats on i_req (kind, page, frame) and every
// request, whatever its kind, yields exactly one response beat on o_rsp (hit,
// frame_out, slot). Both channels use valid/ready; a beat moves at a rising edge
// where both are high. The entry count register sits behind a small APB-style
// port at byte address 0. The user must write it only while idle; the block
// does not enforce this.
//
// Pipeline. A request is captured in an input register, all compares and the
// victim choice are made combinationally from that register, and the response
// is held in an output register. One request is accepted every cycle while the
// response side does not stall; the entry array state is updated at the same
// edge that loads the response register.
//
// Stalls. When o_rsp.ready is low the output register holds its beat, the
// input register holds its request and i_req.ready falls once both are full;
// nothing is dropped. Reset clears every valid bit and use count, zeroes the
// rotation pointer and sets the entry count to five. No clearing pass runs.
module tlb_lfu_lookup_insert #(
    parameter int ENTRIES    = 8,
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tlbl_req_if.sink                        i_req,
    tlbl_rsp_if.source                      o_rsp,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [tlbl_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [tlbl_pkg::APB_DATA_W-1:0] i_pwdata,
    output logic [tlbl_pkg::APB_DATA_W-1:0] o_prdata,
    output logic                            o_pready
);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int LIMIT = (ENTRIES < 15) ? ENTRIES : 15;
    localparam int CNT_W = tlbl_pkg::CNT_W;
    localparam int CFG_W = tlbl_pkg::CFG_W;

    // Entry storage. Page and frame are payload and carry no reset; they are
    // only ever read through a valid entry.
    logic [PAGE_BITS-1:0]  r_page  [ENTRIES];
    logic [FRAME_BITS-1:0] r_frame [ENTRIES];
    logic [CNT_W-1:0]      r_cnt   [ENTRIES];
    logic [CNT_W-1:0]      n_cnt   [ENTRIES];
    logic [ENTRIES-1:0]    r_vld;
    logic [ENTRIES-1:0]    n_vld;
    logic [CFG_W-1:0]      r_ptr;
    logic [CFG_W-1:0]      n_ptr;
    logic [CFG_W-1:0]      r_entries;

    // Input register stage.
    logic                  r_in_vld;
    logic [1:0]            r_kind;
    logic [PAGE_BITS-1:0]  r_pg;
    logic [FRAME_BITS-1:0] r_fr;

    // Output register stage.
    logic                  r_out_vld;
    tlbl_pkg::t_rsp        r_rsp;
    tlbl_pkg::t_rsp        n_rsp;

    logic                  s1_go;
    logic [CFG_W-1:0]      eff_count;
    tlbl_pkg::t_kind       kind;
    logic                  hit;
    logic [ENTRIES-1:0]    hit_oh;
    logic [IDX_W-1:0]      hit_idx;
    logic                  full;
    logic [ENTRIES-1:0]    tgt_oh;
    logic [IDX_W-1:0]      tgt_idx;
    logic [FRAME_BITS-1:0] hit_frame;
    logic                  wr_insert;

    // The stored request moves on whenever the output register is free or
    // being emptied, so a response being taken never blocks the next request.
    assign s1_go       = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || s1_go;

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.hit       = r_rsp.hit;
    assign o_rsp.frame_out = r_rsp.frame_out;
    assign o_rsp.slot      = r_rsp.slot;

    // A count of zero behaves as one, and anything above the table depth
    // behaves as the depth.
    always_comb begin
        if (r_entries == '0) begin
            eff_count = CFG_W'(1);
        end else if (int'(r_entries) > LIMIT) begin
            eff_count = CFG_W'(LIMIT);
        end else begin
            eff_count = r_entries;
        end
    end

    assign kind = tlbl_pkg::t_kind'(r_kind);

    tlbl_match #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS)
    ) u_match (
        .i_page       (r_pg),
        .i_page_store (r_page),
        .i_valid      (r_vld),
        .i_count      (eff_count),
        .o_hit        (hit),
        .o_hit_oh     (hit_oh),
        .o_hit_idx    (hit_idx)
    );

    tlbl_victim #(
        .ENTRIES (ENTRIES)
    ) u_victim (
        .i_cnt     (r_cnt),
        .i_valid   (r_vld),
        .i_count   (eff_count),
        .i_ptr     (r_ptr),
        .o_full    (full),
        .o_tgt_oh  (tgt_oh),
        .o_tgt_idx (tgt_idx)
    );

    // The hit vector is one-hot, so the frame is an AND-OR over the entries.
    always_comb begin
        hit_frame = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit_oh[i]) begin
                hit_frame = hit_frame | r_frame[i];
            end
        end
    end

    // Next state of the entry array and the response beat.
    always_comb begin
        n_vld     = r_vld;
        n_ptr     = r_ptr;
        n_rsp     = '0;
        wr_insert = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            n_cnt[i] = r_cnt[i];
        end
        case (kind)
            tlbl_pkg::KIND_LOOKUP: begin
                if (hit) begin
                    n_rsp.hit       = 1'b1;
                    n_rsp.frame_out = tlbl_pkg::OUT_FRAME_W'(hit_frame);
                    n_rsp.slot      = tlbl_pkg::SLOT_W'(hit_idx);
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (hit_oh[i] && (r_cnt[i] != tlbl_pkg::COUNT_MAX)) begin
                            n_cnt[i] = r_cnt[i] + CNT_W'(1);
                        end
                    end
                end
            end
            tlbl_pkg::KIND_INSERT: begin
                wr_insert  = 1'b1;
                n_rsp.slot = tlbl_pkg::SLOT_W'(tgt_idx);
                n_vld      = r_vld | tgt_oh;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tgt_oh[i] && (r_cnt[i] == '0)) begin
                        n_cnt[i] = CNT_W'(1);
                    end
                end
                // The pointer walks 0..count and wraps, only on replacement.
                if (full) begin
                    n_ptr = (r_ptr < eff_count) ? (r_ptr + CFG_W'(1)) : '0;
                end
            end
            tlbl_pkg::KIND_FLUSH: begin
                n_vld = '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    n_cnt[i] = '0;
                end
            end
            default: begin
                // The unused kind code leaves everything untouched.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_ptr     <= '0;
            r_entries <= tlbl_pkg::RESET_ENTRIES;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (s1_go) begin
                r_vld <= n_vld;
                r_ptr <= n_ptr;
                for (int i = 0; i < ENTRIES; i++) begin
                    r_cnt[i] <= n_cnt[i];
                end
            end
            if (i_req.ready) begin
                r_in_vld <= i_req.valid;
            end
            if (!r_out_vld || o_rsp.ready) begin
                r_out_vld <= r_in_vld;
            end
            if (i_psel && i_penable && i_pwrite
                && (i_paddr[2] == tlbl_pkg::REG_ENTRIES_IN_USE)) begin
                r_entries <= i_pwdata[CFG_W-1:0];
            end
        end
    end

    // Payload registers: request capture, response capture and entry writes.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_kind <= i_req.kind;
            r_pg   <= i_req.page;
            r_fr   <= i_req.frame;
        end
        if (s1_go) begin
            r_rsp <= n_rsp;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (s1_go && wr_insert && tgt_oh[i]) begin
                r_page[i]  <= r_pg;
                r_frame[i] <= r_fr;
            end
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == tlbl_pkg::REG_ENTRIES_IN_USE)
                      ? tlbl_pkg::APB_DATA_W'(r_entries) : '0;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of tlb_lfu_lookup_insert: scripted and random requests,
// each response compared with an in-bench LFU TLB predictor, entry count set over APB.
// Depends on tlbl_pkg, tlbl_if and the RTL of the block.
module tb;

    localparam int N_ENTRIES   = 8;
    localparam int PAGE_W      = 20;
    localparam int FRAME_W     = 20;
    localparam int HOT_PAGES   = 10;
    localparam int PHASE_ITEMS = 52;
    localparam int HOLD_CYCLES = 60;
    localparam int SETTLE      = 8;

    // The package names three kinds; the fourth code must leave the table untouched.
    localparam logic [1:0] KIND_UNDEF = 2'd3;

    localparam logic [tlbl_pkg::APB_ADDR_W-1:0] ADDR_ENTRIES = 3'd0;
    localparam logic [tlbl_pkg::APB_ADDR_W-1:0] ADDR_UNUSED  = 3'd4;

    localparam tlbl_pkg::t_rsp RSP_NONE = '0;

    // One scripted request. Where want_fixed is set the response is typed in here;
    // otherwise it comes from the predictor.
    typedef struct packed {
        logic [1:0]         kind;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic               want_fixed;
        tlbl_pkg::t_rsp     want;
    } t_script_row;

    localparam int N_SCRIPT = 25;

    // Runs from reset, so the table searches five entries.
    localparam t_script_row SCRIPT [N_SCRIPT] = '{
        // Empty table: page zero must not match, nor must the top page.
        '{tlbl_pkg::KIND_LOOKUP, 20'h00000, 20'h00000, 1'b1, '{1'b0, 20'h00000, 3'd0}},
        '{tlbl_pkg::KIND_LOOKUP, 20'hFFFFF, 20'hFFFFF, 1'b1, '{1'b0, 20'h00000, 3'd0}},
        // Fill with extreme pages and frames, then read them back.
        '{tlbl_pkg::KIND_INSERT, 20'h00000, 20'hFFFFF, 1'b1, '{1'b0, 20'h00000, 3'd0}},
        '{tlbl_pkg::KIND_LOOKUP, 20'h00000, 20'h00000, 1'b1, '{1'b1, 20'hFFFFF, 3'd0}},
        '{tlbl_pkg::KIND_INSERT, 20'hFFFFF, 20'h00000, 1'b1, '{1'b0, 20'h00000, 3'd1}},
        '{tlbl_pkg::KIND_LOOKUP, 20'hFFFFF, 20'h00000, 1'b1, '{1'b1, 20'h00000, 3'd1}},
        // A page inserted twice occupies two entries; a lookup takes the lower.
        '{tlbl_pkg::KIND_INSERT, 20'h12345, 20'hABCDE, 1'b1, '{1'b0, 20'h00000, 3'd2}},
        '{tlbl_pkg::KIND_INSERT, 20'h12345, 20'h54321, 1'b1, '{1'b0, 20'h00000, 3'd3}},
        '{tlbl_pkg::KIND_LOOKUP, 20'h12345, 20'h00000, 1'b1, '{1'b1, 20'hABCDE, 3'd2}},
        '{tlbl_pkg::KIND_INSERT, 20'hAAAAA, 20'h55555, 1'b1, '{1'b0, 20'h00000, 3'd4}},
        '{KIND_UNDEF,            20'hFFFFF, 20'hFFFFF, 1'b1, '{1'b0, 20'h00000, 3'd0}},
        // Table full: replacements walk the rotating tie break.
        '{tlbl_pkg::KIND_INSERT, 20'h00001, 20'h00002, 1'b0, RSP_NONE},
        '{tlbl_pkg::KIND_INSERT, 20'h00003, 20'h00004, 1'b0, RSP_NONE},
        '{tlbl_pkg::KIND_LOOKUP, 20'h00003, 20'h00000, 1'b0, RSP_NONE},
        '{tlbl_pkg::KIND_LOOKUP, 20'h54321, 20'h00000, 1'b0, RSP_NONE},
        '{tlbl_pkg::KIND_INSERT, 20'h55555, 20'hAAAAA, 1'b0, RSP_NONE},
        '{tlbl_pkg::KIND_INSERT, 20'h0F0F0, 20'hF0F0F, 1'b0, RSP_NONE},
        '{tlbl_pkg::KIND_INSERT, 20'h00F00, 20'h0F00F, 1'b0, RSP_NONE},
        '{tlbl_pkg::KIND_LOOKUP, 20'hAAAAA, 20'h00000, 1'b0, RSP_NONE},
        // Flush empties everything; the next insert lands in entry zero.
        '{tlbl_pkg::KIND_FLUSH,  20'hFFFFF, 20'hFFFFF, 1'b1, '{1'b0, 20'h00000, 3'd0}},
        '{tlbl_pkg::KIND_LOOKUP, 20'h00000, 20'h00000, 1'b1, '{1'b0, 20'h00000, 3'd0}},
        '{tlbl_pkg::KIND_LOOKUP, 20'h12345, 20'h00000, 1'b1, '{1'b0, 20'h00000, 3'd0}},
        '{tlbl_pkg::KIND_INSERT, 20'h77777, 20'h88888, 1'b1, '{1'b0, 20'h00000, 3'd0}},
        '{tlbl_pkg::KIND_LOOKUP, 20'h77777, 20'h00000, 1'b1, '{1'b1, 20'h88888, 3'd0}},
        '{KIND_UNDEF,            20'h00000, 20'h00000, 1'b1, '{1'b0, 20'h00000, 3'd0}}
    };

    // Entry counts of the random phases: both ends, both out-of-range codes, small tables.
    localparam int ENTRY_PLAN [7] = '{8, 1, 0, 15, 2, 3, 6};

    logic i_clk;
    logic i_rst_n;

    logic                            i_psel;
    logic                            i_penable;
    logic                            i_pwrite;
    logic [tlbl_pkg::APB_ADDR_W-1:0] i_paddr;
    logic [tlbl_pkg::APB_DATA_W-1:0] i_pwdata;
    logic [tlbl_pkg::APB_DATA_W-1:0] o_prdata;
    logic                            o_pready;

    tlbl_req_if #(.PAGE_BITS(PAGE_W), .FRAME_BITS(FRAME_W)) req_ch ();
    tlbl_rsp_if rsp_ch ();

    tlb_lfu_lookup_insert #(
        .ENTRIES    (N_ENTRIES),
        .PAGE_BITS  (PAGE_W),
        .FRAME_BITS (FRAME_W)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .o_rsp     (rsp_ch),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // Predictor state: the table as the block should hold it.
    logic [PAGE_W-1:0]          page_tab  [N_ENTRIES];
    logic [FRAME_W-1:0]         frame_tab [N_ENTRIES];
    logic [tlbl_pkg::CNT_W-1:0] use_cnt   [N_ENTRIES];
    logic                       live      [N_ENTRIES];
    logic [3:0]                 rot_ptr;
    logic [tlbl_pkg::CFG_W-1:0] entries_cfg;

    // Responses owed by the block, oldest first.
    tlbl_pkg::t_rsp pending_translations [$];

    // Side band travelling with each request beat: a typed-in response, if any.
    logic           req_fixed;
    tlbl_pkg::t_rsp req_fixed_rsp;

    bit idling_on;
    bit hold_off_req;

    int mismatches;
    int n_lookups;
    int n_hits;
    int n_inserts;
    int n_flushes;
    int n_other;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous upper bound: the whole run needs well under a tenth of this,
    // even with every stall at its longest.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Works out the response to one request and updates the table copy.
    function automatic tlbl_pkg::t_rsp translate_and_update(input logic [1:0] kind,
                                                            input logic [PAGE_W-1:0] page,
                                                            input logic [FRAME_W-1:0] frame);
        tlbl_pkg::t_rsp             r;
        int                         n;
        int                         tgt;
        int                         first_tie;
        bit                         have_free;
        bit                         tie_seen;
        bit                         picked;
        logic [tlbl_pkg::CNT_W-1:0] least;

        r = '0;
        // Codes 0 and above the table size are clamped to the nearest legal count.
        n = (entries_cfg == 0) ? 1 : ((entries_cfg > N_ENTRIES) ? N_ENTRIES : entries_cfg);
        case (kind)
            tlbl_pkg::KIND_LOOKUP: begin
                for (int i = 0; i < n; i++) begin
                    if (live[i] && page_tab[i] == page) begin
                        if (use_cnt[i] != tlbl_pkg::COUNT_MAX)
                            use_cnt[i]++;
                        r.hit       = 1'b1;
                        r.frame_out = frame_tab[i];
                        r.slot      = tlbl_pkg::SLOT_W'(i);
                        break;
                    end
                end
            end
            tlbl_pkg::KIND_INSERT: begin
                tgt       = 0;
                have_free = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (!live[i]) begin
                        tgt       = i;
                        have_free = 1'b1;
                        break;
                    end
                end
                if (!have_free) begin
                    // Exact minimum, then the first tie at or after the pointer,
                    // else the first tie overall.
                    least = tlbl_pkg::COUNT_MAX;
                    for (int i = 0; i < n; i++)
                        if (use_cnt[i] < least)
                            least = use_cnt[i];
                    tie_seen  = 1'b0;
                    picked    = 1'b0;
                    first_tie = 0;
                    for (int i = 0; i < n; i++) begin
                        if (use_cnt[i] == least) begin
                            if (!tie_seen) begin
                                first_tie = i;
                                tie_seen  = 1'b1;
                            end
                            if (!picked && i >= rot_ptr) begin
                                tgt    = i;
                                picked = 1'b1;
                            end
                        end
                    end
                    if (!picked)
                        tgt = first_tie;
                    rot_ptr = (rot_ptr < n) ? rot_ptr + 4'd1 : 4'd0;
                end
                page_tab[tgt]  = page;
                frame_tab[tgt] = frame;
                live[tgt]      = 1'b1;
                if (use_cnt[tgt] == 0)
                    use_cnt[tgt] = tlbl_pkg::CNT_W'(1);
                r.slot = tlbl_pkg::SLOT_W'(tgt);
            end
            tlbl_pkg::KIND_FLUSH: begin
                // The rotation pointer survives a flush.
                for (int i = 0; i < N_ENTRIES; i++) begin
                    page_tab[i]  = '0;
                    frame_tab[i] = '0;
                    use_cnt[i]   = '0;
                    live[i]      = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Response check first, then the request accepted at the same edge: the
    // block registers a request before answering, so a beat never answers itself.
    always @(posedge i_clk) begin : rsp_check
        tlbl_pkg::t_rsp got;
        tlbl_pkg::t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < N_ENTRIES; i++) begin
                page_tab[i]  = '0;
                frame_tab[i] = '0;
                use_cnt[i]   = '0;
                live[i]      = 1'b0;
            end
            rot_ptr     = '0;
            entries_cfg = tlbl_pkg::RESET_ENTRIES;
            pending_translations.delete();
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.hit       = rsp_ch.hit;
                got.frame_out = rsp_ch.frame_out;
                got.slot      = rsp_ch.slot;
                if (got.hit === 1'b1)
                    n_hits++;
                if (pending_translations.size() == 0) begin
                    report_mismatch($sformatf("unrequested beat hit=%b frame=%05h slot=%0d",
                                              got.hit, got.frame_out, got.slot));
                end else begin
                    want = pending_translations.pop_front();
                    if (got.hit !== want.hit || got.frame_out !== want.frame_out ||
                        got.slot !== want.slot)
                        report_mismatch($sformatf(
                            "expected hit=%b frame=%05h slot=%0d, got hit=%b frame=%05h slot=%0d",
                            want.hit, want.frame_out, want.slot,
                            got.hit, got.frame_out, got.slot));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                want = translate_and_update(req_ch.kind, req_ch.page, req_ch.frame);
                if (req_fixed)
                    want = req_fixed_rsp;
                pending_translations.push_back(want);
                case (req_ch.kind)
                    tlbl_pkg::KIND_LOOKUP: n_lookups++;
                    tlbl_pkg::KIND_INSERT: n_inserts++;
                    tlbl_pkg::KIND_FLUSH:  n_flushes++;
                    default:               n_other++;
                endcase
            end
        end
    end

    // Response side: random stalls, plus one long hold-off on request so the
    // block fills up and pushes back on its input.
    initial begin : rsp_ready_drive
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Called at a clock edge; returns at the edge where the beat is accepted,
    // leaving valid high so the next request can follow back to back.
    task automatic send_request(input logic [1:0] kind, input logic [PAGE_W-1:0] page,
                                input logic [FRAME_W-1:0] frame, input logic fixed,
                                input tlbl_pkg::t_rsp want);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.kind   <= kind;
        req_ch.page   <= page;
        req_ch.frame  <= frame;
        req_fixed     <= fixed;
        req_fixed_rsp <= want;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Drops valid and waits for every owed response, then a few quiet cycles.
    // The first edge lets the checker record the last accepted request.
    task automatic wait_until_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_translations.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [tlbl_pkg::APB_ADDR_W-1:0] addr,
                             input logic [tlbl_pkg::APB_DATA_W-1:0] data);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= addr;
        i_pwdata  <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        // Only the entry count register exists; other addresses are ignored.
        if (addr[2] == tlbl_pkg::REG_ENTRIES_IN_USE)
            entries_cfg = data[tlbl_pkg::CFG_W-1:0];
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_read_check(input logic [tlbl_pkg::APB_ADDR_W-1:0] addr,
                                  input logic [tlbl_pkg::APB_DATA_W-1:0] want);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        i_paddr   <= addr;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        if (o_prdata !== want)
            report_mismatch($sformatf("register read at %0d: expected %08h, got %08h",
                                      addr, want, o_prdata));
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly a small set of hot pages so that lookups hit and inserts fill the
    // table and force replacements; the rest are arbitrary pages, flushes and
    // the undefined kind.
    task automatic run_random_phase(input int n_items);
        logic [1:0]         kind;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  hot_pages [HOT_PAGES];
        int                 pick;
        for (int k = 0; k < HOT_PAGES; k++)
            hot_pages[k] = PAGE_W'($urandom);
        for (int j = 0; j < n_items; j++) begin
            pick  = $urandom_range(0, 99);
            frame = FRAME_W'($urandom);
            if ($urandom_range(0, 99) < 80)
                page = hot_pages[$urandom_range(0, HOT_PAGES - 1)];
            else
                page = PAGE_W'($urandom);
            if (pick < 50)
                kind = tlbl_pkg::KIND_LOOKUP;
            else if (pick < 94)
                kind = tlbl_pkg::KIND_INSERT;
            else if (pick < 97)
                kind = tlbl_pkg::KIND_FLUSH;
            else
                kind = KIND_UNDEF;
            send_request(kind, page, frame, 1'b0, RSP_NONE);
        end
    endtask

    initial begin : stimulus
        logic [tlbl_pkg::CFG_W-1:0] cfg_val;

        i_rst_n       <= 1'b0;
        i_psel        <= 1'b0;
        i_penable     <= 1'b0;
        i_pwrite      <= 1'b0;
        i_paddr       <= '0;
        i_pwdata      <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.kind   <= '0;
        req_ch.page   <= '0;
        req_ch.frame  <= '0;
        req_fixed     <= 1'b0;
        req_fixed_rsp <= RSP_NONE;
        idling_on     = 1'b1;
        hold_off_req  = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_read_check(ADDR_ENTRIES, tlbl_pkg::APB_DATA_W'(tlbl_pkg::RESET_ENTRIES));

        for (int r = 0; r < N_SCRIPT; r++)
            send_request(SCRIPT[r].kind, SCRIPT[r].page, SCRIPT[r].frame,
                         SCRIPT[r].want_fixed, SCRIPT[r].want);
        wait_until_idle();

        // The table is not flushed between phases, so shrinking the count leaves
        // entries beyond it intact, and a later larger count brings them back.
        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6)
                cfg_val = tlbl_pkg::CFG_W'($urandom_range(4, 7));
            else
                cfg_val = tlbl_pkg::CFG_W'(ENTRY_PLAN[ph]);
            if (ph == 3) begin
                // A write to an address with no register must change nothing.
                cfg_write(ADDR_UNUSED, tlbl_pkg::APB_DATA_W'($urandom_range(0, 15)));
                cfg_read_check(ADDR_ENTRIES, tlbl_pkg::APB_DATA_W'(entries_cfg));
            end
            cfg_write(ADDR_ENTRIES, tlbl_pkg::APB_DATA_W'(cfg_val));
            cfg_read_check(ADDR_ENTRIES, tlbl_pkg::APB_DATA_W'(cfg_val));
            idling_on = (ph != 1);
            if (ph == 4)
                hold_off_req = 1'b1;
            run_random_phase(PHASE_ITEMS);
            wait_until_idle();
        end

        // Use-count ordering with two entries: page 3C3C3 reaches a count of 6,
        // page C3C3C a count of 13, so the next insert must evict 3C3C3.
        idling_on = 1'b0;
        cfg_write(ADDR_ENTRIES, tlbl_pkg::APB_DATA_W'(2));
        send_request(tlbl_pkg::KIND_FLUSH, 20'h00000, 20'h00000, 1'b1, RSP_NONE);
        send_request(tlbl_pkg::KIND_INSERT, 20'hC3C3C, 20'h13579, 1'b1,
                     '{1'b0, 20'h00000, 3'd0});
        send_request(tlbl_pkg::KIND_INSERT, 20'h3C3C3, 20'h2468A, 1'b1,
                     '{1'b0, 20'h00000, 3'd1});
        repeat (5)
            send_request(tlbl_pkg::KIND_LOOKUP, 20'h3C3C3, 20'h00000, 1'b0, RSP_NONE);
        repeat (12)
            send_request(tlbl_pkg::KIND_LOOKUP, 20'hC3C3C, 20'h00000, 1'b0, RSP_NONE);
        send_request(tlbl_pkg::KIND_INSERT, 20'h5A5A5, 20'hFFFFF, 1'b1,
                     '{1'b0, 20'h00000, 3'd1});
        send_request(tlbl_pkg::KIND_LOOKUP, 20'hC3C3C, 20'h00000, 1'b0, RSP_NONE);
        send_request(tlbl_pkg::KIND_LOOKUP, 20'h3C3C3, 20'h00000, 1'b0, RSP_NONE);
        wait_until_idle();

        // Closing phase at full rate on both sides.
        cfg_write(ADDR_ENTRIES, tlbl_pkg::APB_DATA_W'(7));
        cfg_read_check(ADDR_ENTRIES, tlbl_pkg::APB_DATA_W'(7));
        run_random_phase(PHASE_ITEMS);
        wait_until_idle();

        $display("covered %0d lookups (%0d hits), %0d inserts, %0d flushes, %0d undefined kinds",
                 n_lookups, n_hits, n_inserts, n_flushes, n_other);
        $display("entry counts 0 to 15 incl. out-of-range codes, LFU eviction order, %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/tlbl_pkg.sv
hw/rtl/tlbl_if.sv
hw/rtl/tlbl_match.sv
hw/rtl/tlbl_victim.sv
hw/rtl/tlb_lfu_lookup_insert.sv
tb/tb.sv
